// ----- hdl/spq_pkg.sv -----
// shared types and constants for the stable priority queue
// no dependencies; imported by every module of the block
package spq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PRIO_WIDTH = 16;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // operation broadcast to every cell
  typedef struct packed {
    logic                  ins;
    logic                  pop;
    logic [PRIO_WIDTH-1:0] prio;
    logic [DATA_WIDTH-1:0] data;
  } cell_ctrl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                  ge;
    logic [PRIO_WIDTH-1:0] prio;
    logic [DATA_WIDTH-1:0] data;
  } cell_link_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] front_data;
    status_e               status;
    logic [CNT_W-1:0]      entry_count;
  } result_t;

endpackage

// ----- hdl/stable_priority_queue_unit.sv -----
// top level of the stable priority queue: cell chain, entry count, result buffer
// depends on spq_pkg, spq_cell and spq_out_buf

// A sorted priority queue of DEPTH entries built as a chain of cells, head at
// cell 0. Every transaction, insert or pop, is accepted unless input stalls
// and its result is registered in the output buffer, so the block sustains
// one item per clock when not stalled; the cell chain does the whole insert
// or shift in one register update. A two-entry output buffer lets input keep
// flowing while a result waits; input stalls only when both entries are held.
// Equal priorities leave in arrival order. A pop on an empty queue and an
// insert into a full queue leave the state unchanged and are reported in status.
module stable_priority_queue_unit import spq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [DATA_WIDTH-1:0] entry_data_i,
  input  logic [PRIO_WIDTH-1:0] entry_priority_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] front_data_o,
  output logic [1:0]            status_o,
  output logic [CNT_W-1:0]      entry_count_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             accept, is_pop, is_full, is_empty, ins_ok, pop_ok;
  logic             buf_full;
  cell_ctrl_t       ctrl;
  cell_link_t       links [DEPTH];
  cell_link_t       head_left;
  result_t          res, out_res;

  assign accept   = in_valid_i && !in_stall_o;
  assign is_pop   = (cmd_e'(cmd_i) == CMD_POP);
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign ins_ok   = accept && !is_pop && !is_full;
  assign pop_ok   = accept && is_pop && !is_empty;

  assign ctrl.ins  = ins_ok;
  assign ctrl.pop  = pop_ok;
  assign ctrl.prio = entry_priority_i;
  assign ctrl.data = entry_data_i;

  // everything ahead of the head counts as higher priority
  assign head_left.ge   = 1'b1;
  assign head_left.prio = '0;
  assign head_left.data = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t left_l, right_l;
    if (i == 0) begin : g_head
      assign left_l = head_left;
    end else begin : g_mid
      assign left_l = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_l = links[i];
    end else begin : g_body
      assign right_l = links[i+1];
    end
    spq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .occ_i   (CNT_W'(i) < count_q),
      .left_i  (left_l),
      .right_i (right_l),
      .link_o  (links[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    res.front_data  = pop_ok ? links[0].data : '0;
    res.entry_count = count_d;
    if (is_pop && is_empty) begin
      res.status = ST_EMPTY;
    end else if (!is_pop && is_full) begin
      res.status = ST_FULL;
    end else begin
      res.status = ST_OK;
    end
  end

  spq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign in_stall_o    = buf_full;
  assign front_data_o  = out_res.front_data;
  assign status_o      = out_res.status;
  assign entry_count_o = out_res.entry_count;

endmodule

// ----- hdl/spq_cell.sv -----
// one slot of the sorted chain: holds a (priority, data) entry
// depends on spq_pkg; instantiated DEPTH times by the top level
module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  cell_link_t left_i,
  input  cell_link_t right_i,
  output cell_link_t link_o
);

  logic [PRIO_WIDTH-1:0] prio_q, prio_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  ge;

  assign ge = occ_i && (prio_q >= ctrl_i.prio);

  always_comb begin
    prio_d = prio_q;
    data_d = data_q;
    if (ctrl_i.ins && !ge) begin
      // insert point when everything to the left stays put
      if (left_i.ge) begin
        prio_d = ctrl_i.prio;
        data_d = ctrl_i.data;
      end else begin
        prio_d = left_i.prio;
        data_d = left_i.data;
      end
    end else if (ctrl_i.pop) begin
      prio_d = right_i.prio;
      data_d = right_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign link_o.ge   = ge;
  assign link_o.prio = prio_q;
  assign link_o.data = data_q;

endmodule

// ----- hdl/spq_out_buf.sv -----
// two-entry result buffer: output register plus skid register
// depends on spq_pkg; used by the top level
module spq_out_buf import spq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_take;

  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_take) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- bench/spq_checker.sv -----
`timescale 1ns / 100ps
// checker for the stable priority queue: keeps its own sorted list, predicts each result
// and compares it with what the block returns; depends on spq_pkg
module spq_checker import spq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  cmd_i,
  input  logic [DATA_WIDTH-1:0] entry_data_i,
  input  logic [PRIO_WIDTH-1:0] entry_priority_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [DATA_WIDTH-1:0] front_data_i,
  input  logic [1:0]            status_i,
  input  logic [CNT_W-1:0]      entry_count_i,
  output int                    mismatch_count_o,
  output int                    awaited_o,
  output int                    checked_o,
  output int                    empty_hits_o,
  output int                    full_hits_o
);

  logic [PRIO_WIDTH-1:0] sorted_prio [DEPTH];
  logic [DATA_WIDTH-1:0] sorted_data [DEPTH];
  int                    held;
  result_t               awaited_results [$];
  result_t               want;

  function automatic result_t sorted_list_update(input cmd_e op,
                                                 input logic [DATA_WIDTH-1:0] d,
                                                 input logic [PRIO_WIDTH-1:0] p);
    result_t r;
    int      slot;
    int      k;
    r.front_data = '0;
    r.status     = ST_OK;
    if (op == CMD_INSERT) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot = 0;
        while (slot < held && sorted_prio[slot] >= p) slot++;
        for (k = held; k > slot; k--) begin
          sorted_prio[k] = sorted_prio[k-1];
          sorted_data[k] = sorted_data[k-1];
        end
        sorted_prio[slot] = p;
        sorted_data[slot] = d;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.front_data = sorted_data[0];
        for (k = 1; k < held; k++) begin
          sorted_prio[k-1] = sorted_prio[k];
          sorted_data[k-1] = sorted_data[k];
        end
        held--;
      end
    end
    r.entry_count = CNT_W'(held);
    return r;
  endfunction

  initial begin
    mismatch_count_o = 0;
    awaited_o        = 0;
    checked_o        = 0;
    empty_hits_o     = 0;
    full_hits_o      = 0;
    held             = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      awaited_results.delete();
      awaited_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with no transaction waiting: front_data %h status %0d entry_count %0d",
                 front_data_i, status_i, entry_count_i);
          mismatch_count_o++;
        end else begin
          want = awaited_results.pop_front();
          checked_o++;
          if (front_data_i !== want.front_data) begin
            $error("front_data: expected %h, actual %h", want.front_data, front_data_i);
            mismatch_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            mismatch_count_o++;
          end
          if (entry_count_i !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = sorted_list_update(cmd_e'(cmd_i), entry_data_i, entry_priority_i);
        if (want.status == ST_EMPTY) empty_hits_o++;
        if (want.status == ST_FULL) full_hits_o++;
        awaited_results.push_back(want);
      end
      awaited_o = awaited_results.size();
    end
  end

endmodule

// ----- bench/stable_priority_queue_unit_tb.sv -----
`timescale 1ns / 100ps
// top of the stable priority queue testbench: clock, reset, stimulus and verdict
// depends on spq_pkg, stable_priority_queue_unit and spq_checker
module stable_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  cmd;
  logic [DATA_WIDTH-1:0] entry_data;
  logic [PRIO_WIDTH-1:0] entry_priority;
  logic                  out_valid;
  logic                  out_stall;
  logic [DATA_WIDTH-1:0] front_data;
  logic [1:0]            status;
  logic [CNT_W-1:0]      entry_count;

  int mismatches;
  int awaited;
  int checked;
  int empty_hits;
  int full_hits;
  int inserts_sent;
  int pops_sent;
  int cycles;
  bit no_gaps;

  logic [PRIO_WIDTH-1:0] fill_prio [16] = '{
    16'h0000, 16'hFFFF, 16'h0005, 16'h0005, 16'h0005, 16'hFFFF, 16'h0000, 16'h8000,
    16'h7FFF, 16'h0005, 16'h0001, 16'hFFFE, 16'h0000, 16'h8000, 16'h0005, 16'hFFFF
  };

  stable_priority_queue_unit i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .cmd_i            (cmd),
    .entry_data_i     (entry_data),
    .entry_priority_i (entry_priority),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .front_data_o     (front_data),
    .status_o         (status),
    .entry_count_o    (entry_count)
  );

  spq_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .cmd_i            (cmd),
    .entry_data_i     (entry_data),
    .entry_priority_i (entry_priority),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .front_data_i     (front_data),
    .status_i         (status),
    .entry_count_i    (entry_count),
    .mismatch_count_o (mismatches),
    .awaited_o        (awaited),
    .checked_o        (checked),
    .empty_hits_o     (empty_hits),
    .full_hits_o      (full_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [PRIO_WIDTH-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return PRIO_WIDTH'($urandom_range(0, 7));
    if (r == 4) return PRIO_WIDTH'($urandom_range(16'hFFF8, 16'hFFFF));
    if (r < 8) return PRIO_WIDTH'($urandom());
    if (r == 8) return '0;
    return '1;
  endfunction

  task automatic send_item(input cmd_e op, input logic [DATA_WIDTH-1:0] d,
                           input logic [PRIO_WIDTH-1:0] p);
    int gap;
    in_valid       <= 1'b1;
    cmd            <= op;
    entry_data     <= d;
    entry_priority <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == CMD_INSERT) inserts_sent++;
    else pops_sent++;
    gap = no_gaps ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver side stall pattern
  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (pick_idle() + 1) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int   n;
    int   i;
    int   ins_pct;
    cmd_e op;
    in_valid       <= 1'b0;
    cmd            <= CMD_INSERT;
    entry_data     <= '0;
    entry_priority <= '0;
    rst_n          <= 1'b0;
    no_gaps        = 1'b0;
    inserts_sent   = 0;
    pops_sent      = 0;
    ins_pct        = 50;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pop on empty, fill with ties and extremes, insert into full, a few pops
    send_item(CMD_POP, '1, '1);
    for (i = 0; i < 16; i++) begin
      send_item(CMD_INSERT,
                (i == 0) ? '0 : (i == 1) ? '1 : {4'(i), 28'h0ABCDEF},
                fill_prio[i]);
    end
    send_item(CMD_INSERT, 32'h5A5A_A5A5, 16'hFFFF);
    send_item(CMD_POP, '0, '0);
    send_item(CMD_POP, '1, '1);
    send_item(CMD_POP, 32'hA5A5_5A5A, 16'h1234);
    send_item(CMD_POP, '0, '1);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 80;
          1: ins_pct = 20;
          default: ins_pct = 50;
        endcase
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      op = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_POP;
      send_item(op, $urandom(), pick_priority());
    end
    in_valid <= 1'b0;

    while (awaited != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d transactions: %0d inserts and %0d pops, %0d results checked",
             inserts_sent + pops_sent, inserts_sent, pops_sent, checked);
    $display("pops on an empty queue: %0d, inserts dropped on a full queue: %0d",
             empty_hits, full_hits);
    if (mismatches == 0 && awaited == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/spq_out_buf.sv
hdl/stable_priority_queue_unit.sv
bench/spq_checker.sv
bench/stable_priority_queue_unit_tb.sv
